@@ src/rms_sound_level_db_meter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sound level meter
// Clocked on clk, disabled while arst_n is low; compile with ASSERT_OFF to drop.
// ----------------------------------------------------------------------------
`ifndef RMS_SOUND_LEVEL_DB_METER_ASSERT_SVH
`define RMS_SOUND_LEVEL_DB_METER_ASSERT_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define RSLDM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rsldm assertion failed");
// expression must never be true out of reset
`define RSLDM_ASSERT_NEVER(lbl, expr) \
	`RSLDM_ASSERT(lbl, !(expr))
`else
`define RSLDM_ASSERT(lbl, prop)
`define RSLDM_ASSERT_NEVER(lbl, expr)
`endif
`endif

@@ src/rsldm_pkg.sv @@
// ----------------------------------------------------------------------------
// rsldm_pkg
// Widths, constants and controller/datapath interface types of the meter.
// ----------------------------------------------------------------------------
`default_nettype none

package rsldm_pkg;

	localparam int SAMPLE_W = 10;
	localparam int SQ_W     = 19;
	localparam int SUM_W    = 29;
	localparam int CNT_W    = 11;
	localparam int MEAN_W   = 19;
	localparam int EXP_W    = 5;
	localparam int FRAC_W   = 16;
	localparam int LOG_W    = EXP_W + FRAC_W;
	localparam int X_W      = 31;
	localparam int KQ_W     = 35;
	localparam int KQ_LO_W  = 17;
	localparam int KQ_HI_W  = KQ_W - KQ_LO_W;
	localparam int PLO_W    = LOG_W + KQ_LO_W;
	localparam int PHI_W    = LOG_W + KQ_HI_W;
	localparam int PROD_W   = 56;
	localparam int LEVEL_W  = 7;
	localparam int STEP_W   = 5;

	localparam logic [CNT_W-1:0]    WIN_RESET  = 11'd128;
	localparam logic [CNT_W-1:0]    MAX_WINDOW = 11'd1024;
	localparam logic [SAMPLE_W-1:0] MID_SCALE  = 10'd512;
	// exponent of a freshly loaded quotient before normalization
	localparam logic [EXP_W-1:0]    EXP_INIT   = 5'd18;
	// 20.0 in Q16
	localparam logic [LOG_W-1:0]    LOG_TOP    = 21'd1310720;
	// 16*log10(2) in Q32
	localparam logic [KQ_W-1:0]     KQ         = 35'd20686623784;
	localparam logic [8:0]          LEVEL_TOP  = 9'd110;
	localparam logic [STEP_W-1:0]   DIV_STEPS  = 5'd19;
	localparam logic [STEP_W-1:0]   LOG_STEPS  = 5'd16;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic div_step;
		logic norm_step;
		logic log_start;
		logic log_step;
		logic mul_lo;
		logic mul_hi;
		logic mul_sum;
		logic load_out;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic win_full;
		logic mean_zero;
		logic norm_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ src/rsldm_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsldm_ctrl
// Sequencer: accumulate, divide, normalize, log2, scale, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module rsldm_ctrl import rsldm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_NORM = 3'd2;
	localparam logic [2:0] ST_LOG  = 3'd3;
	localparam logic [2:0] ST_MLO  = 3'd4;
	localparam logic [2:0] ST_MHI  = 3'd5;
	localparam logic [2:0] ST_SUM  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0]        state_q;
	logic [2:0]        state_nxt;
	logic [STEP_W-1:0] step_q;

	// next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		s_tready  = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (sts.win_full) begin
						state_nxt = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == DIV_STEPS - 1'b1) begin
					state_nxt = ST_NORM;
				end
			end
			ST_NORM: begin
				if (sts.mean_zero) begin
					state_nxt = ST_OUT;
				end else if (sts.norm_done) begin
					cmd.log_start = 1'b1;
					state_nxt     = ST_LOG;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			ST_LOG: begin
				cmd.log_step = 1'b1;
				if (step_q == LOG_STEPS - 1'b1) begin
					state_nxt = ST_MLO;
				end
			end
			ST_MLO: begin
				cmd.mul_lo = 1'b1;
				state_nxt  = ST_MHI;
			end
			ST_MHI: begin
				cmd.mul_hi = 1'b1;
				state_nxt  = ST_SUM;
			end
			ST_SUM: begin
				cmd.mul_sum = 1'b1;
				state_nxt   = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// advance state; restart the step count on every transition
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_nxt != state_q) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/rsldm_dp.sv @@
// ----------------------------------------------------------------------------
// rsldm_dp
// Accumulator, restoring divider, log2 by squaring, scale multiply, output.
// ----------------------------------------------------------------------------
`default_nettype none

module rsldm_dp import rsldm_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                cmd,
	output sts_t                     sts,
	input  wire logic [SAMPLE_W-1:0] sample,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata,
	output logic                     m_tuser,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CNT_W-1:0]    cfg_data
);

	logic [CNT_W-1:0]    win_len_q;
	logic [CNT_W-1:0]    win_eff;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SAMPLE_W-1:0] amp;
	logic [2*SAMPLE_W-1:0] amp_sq;
	logic [SUM_W-1:0]    sum_nxt;
	logic [CNT_W-1:0]    cnt_nxt;

	logic [CNT_W-1:0]    den_q;
	logic [CNT_W-1:0]    rem_q;
	logic [MEAN_W-1:0]   dq_q;
	logic [CNT_W:0]      div_trial;
	logic [CNT_W:0]      div_diff;
	logic                div_ge;

	logic [EXP_W-1:0]    exp_q;
	logic [X_W-1:0]      x_q;
	logic [2*X_W-1:0]    x_sq;
	logic [FRAC_W-1:0]   frac_q;
	logic [LOG_W-1:0]    log_d;

	logic [PLO_W-1:0]    plo_s1;
	logic [PHI_W-1:0]    phi_s1;
	logic [PROD_W-1:0]   prod_q;
	logic [8:0]          ceil_c;
	logic [8:0]          level;
	logic                silent;

	logic                m_tvalid_q;
	logic [7:0]          m_tdata_q;
	logic                m_tuser_q;

	assign cfg_ready = 1'b1;

	// clamp the window to 1..MAX_WINDOW
	always_comb begin
		if (win_len_q == '0) begin
			win_eff = CNT_W'(1);
		end else if (win_len_q > MAX_WINDOW) begin
			win_eff = MAX_WINDOW;
		end else begin
			win_eff = win_len_q;
		end
	end

	// square of the distance from mid-scale
	assign amp     = (sample >= MID_SCALE) ? (sample - MID_SCALE) : (MID_SCALE - sample);
	assign amp_sq  = amp * amp;
	assign sum_nxt = sum_q + SUM_W'(amp_sq[SQ_W-1:0]);
	assign cnt_nxt = cnt_q + 1'b1;

	// restoring divide step
	assign div_trial = {rem_q, dq_q[MEAN_W-1]};
	assign div_diff  = div_trial - {1'b0, den_q};
	assign div_ge    = (div_trial >= {1'b0, den_q});

	// log2 fraction by repeated squaring of the Q30 mantissa
	assign x_sq  = x_q * x_q;
	assign log_d = LOG_TOP - {exp_q, frac_q};

	// level = 110 - ceil(P / 2^48), floored at zero
	assign ceil_c = {1'b0, prod_q[PROD_W-1:48]} + 9'(|prod_q[47:0]);
	assign level  = (ceil_c > LEVEL_TOP) ? 9'd0 : (LEVEL_TOP - ceil_c);
	assign silent = (dq_q == '0);

	assign sts.win_full  = (cnt_nxt >= win_eff);
	assign sts.mean_zero = silent;
	assign sts.norm_done = dq_q[MEAN_W-1];
	assign sts.out_free  = !m_tvalid_q || m_tready;

	// configuration, accumulator and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q  <= WIN_RESET;
			sum_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				win_len_q <= cfg_data;
			end
			if (cmd.accept) begin
				if (sts.win_full) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_nxt;
					cnt_q <= cnt_nxt;
				end
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// divider, log and scale registers
	always_ff @(posedge clk) begin
		if (cmd.accept && sts.win_full) begin
			den_q <= cnt_nxt;
			rem_q <= {1'b0, sum_nxt[SUM_W-1:MEAN_W]};
			dq_q  <= sum_nxt[MEAN_W-1:0];
			exp_q <= EXP_INIT;
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
			dq_q  <= {dq_q[MEAN_W-2:0], div_ge};
		end
		if (cmd.norm_step) begin
			dq_q  <= {dq_q[MEAN_W-2:0], 1'b0};
			exp_q <= exp_q - 1'b1;
		end
		if (cmd.log_start) begin
			x_q    <= {dq_q, (X_W - MEAN_W)'(0)};
			frac_q <= '0;
		end
		if (cmd.log_step) begin
			x_q    <= x_sq[2*X_W-1] ? x_sq[2*X_W-1:X_W] : x_sq[2*X_W-2:X_W-1];
			frac_q <= {frac_q[FRAC_W-2:0], x_sq[2*X_W-1]};
		end
		if (cmd.mul_lo) begin
			plo_s1 <= PLO_W'(log_d) * PLO_W'(KQ[KQ_LO_W-1:0]);
		end
		if (cmd.mul_hi) begin
			phi_s1 <= PHI_W'(log_d) * PHI_W'(KQ[KQ_W-1:KQ_LO_W]);
		end
		if (cmd.mul_sum) begin
			prod_q <= PROD_W'({phi_s1, KQ_LO_W'(0)}) + PROD_W'(plo_s1);
		end
		if (cmd.load_out) begin
			m_tdata_q <= silent ? 8'd0 : {1'b0, level[LEVEL_W-1:0]};
			m_tuser_q <= silent;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

@@ src/rms_sound_level_db_meter.sv @@
// ----------------------------------------------------------------------------
// rms_sound_level_db_meter
// Mean-square sound level meter with a calibrated whole-decibel output.
// ----------------------------------------------------------------------------
// Input stream s_*: one 10-bit ADC sample per transaction, mid-scale 512 is
// silence. Output stream m_*: one level per window of window_len samples.
// cfg_* writes window_len (0 acts as 1, above 1024 acts as 1024); write it
// only while the block is idle. cfg_ready is always high.
// A sample that does not close the window is just accumulated. A closing
// sample starts the end-of-window sequence: restoring division, leading-one
// normalization, the squaring loop of the log2 unit, split multiply and sum,
// and the output load, which waits until the output register is free;
// a zero mean skips from normalization straight to the output load.
// The squaring multiplier in the log2 loop and the one-bit-per-cycle divider
// set the length of the sequence; s_tready stays low during the sequence.
// The result sits in an output register: while the receiver stalls, further
// samples are still taken until the next window closes, and then the block
// waits with the new level until the old one is taken.
// Reset clears the accumulator, the sample count and the output valid, and
// sets window_len to 128.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rms_sound_level_db_meter_assert.svh"

module rms_sound_level_db_meter import rsldm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,    // [9:0] sample, [15:10] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,    // [6:0] level_db, [7] zero
	output logic             m_tuser,    // [0] silent
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [10:0] cfg_data    // window_len
);

	cmd_t cmd;
	sts_t sts;

	rsldm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsldm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.sample    (s_tdata[SAMPLE_W-1:0]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// checks
	`RSLDM_ASSERT(a_one_cmd, $onehot0(cmd))
	`RSLDM_ASSERT(a_load_when_free, cmd.load_out |-> (!m_tvalid || m_tready))
	`RSLDM_ASSERT(a_silent_zero, (m_tvalid && m_tuser) |-> (m_tdata == 8'd0))
	`RSLDM_ASSERT(a_level_range, (m_tvalid && !m_tuser) |-> (m_tdata >= 8'd13 && m_tdata <= 8'd100))
	`RSLDM_ASSERT_NEVER(a_no_accept_busy, cmd.accept && $past(cmd.accept && sts.win_full))

endmodule

`default_nettype wire
